### rtl/bps_pkg.sv
// shared types, constants and helpers for the byte pattern search block
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

	localparam int PAT_BYTES = 16;
	localparam int PAT_W     = 8 * PAT_BYTES;
	localparam int LEN_W     = 5;
	localparam int OFS_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;
	localparam int OUT_W     = 24;

	typedef logic [7:0]       byte_t;
	typedef logic [PAT_W-1:0] pattern_t;
	typedef logic [LEN_W-1:0] pat_len_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_HIGH = 2'd1,
		CFG_PAT_LEN  = 2'd2
	} cfg_idx_t;

	function automatic byte_t pat_byte(input pattern_t pat, input logic [3:0] idx);
		pat_byte = pat[{idx, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

### rtl/bps_cell.sv
// one window cell: holds one earlier haystack byte and compares it with its pattern byte
`timescale 1ns / 1ps
`default_nettype none
module bps_cell #(
	parameter int CELL_IDX = 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 shift,
	input  wire bps_pkg::byte_t    byte_in,
	input  wire bps_pkg::pattern_t pattern,
	input  wire bps_pkg::pat_len_t pat_len,
	output bps_pkg::byte_t         byte_out,
	output logic                hit
);
	import bps_pkg::*;

	byte_t    byte_q;
	pat_len_t pat_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	// this cell sits CELL_IDX bytes before the newest one
	assign pat_idx  = pat_len - LEN_W'(1) - LEN_W'(CELL_IDX);
	assign hit      = (LEN_W'(CELL_IDX) >= pat_len) ||
	                  (byte_q == pat_byte(pattern, pat_idx[3:0]));
	assign byte_out = byte_q;

endmodule
`default_nettype wire

### rtl/byte_pattern_search_top.sv
// top level of the byte pattern search: config registers, cell chain, match tracking, output
// Usage:
//   s_tdata carries one haystack byte per item, s_tlast marks the final byte.
//   cfg_valid/cfg_ready with cfg_index and cfg_data write pattern_low (0),
//   pattern_high (1) and pattern_length (2); cfg_ready is always high.
//   One result item per haystack leaves on m_tdata: found in bit 0,
//   match_offset in bits 16:1, overflow in bit 17.
//   Throughput is one byte per cycle while no result waits: every byte is
//   compared against the whole pattern by a chain of MAX_PATTERN-1 window
//   cells plus the compare on the incoming byte.
//   The result is registered and valid in the cycle after the last byte is accepted.
//   The result waits in the output register while m_tready is low; s_tready
//   stays low for as long as a result waits, so input stalls until it is
//   taken, and a new byte can be accepted in the cycle it leaves.
//   Reset clears the pattern registers, the stream state and the output valid.
//   After each result the position, match and overflow state start over.
`timescale 1ns / 1ps
`default_nettype none
module byte_pattern_search_top #(
	parameter int              MAX_PATTERN  = 16,
	parameter longint unsigned MAX_HAYSTACK = 65536
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [7:0]                          s_tdata,   // data_byte
	input  wire                                 s_tlast,   // last_byte
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [bps_pkg::OUT_W-1:0]           m_tdata,   // found, match_offset, overflow
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [bps_pkg::CFG_W-1:0]           cfg_data
);
	import bps_pkg::*;

	localparam int CNT_W = $clog2(MAX_HAYSTACK + 1);
	localparam logic [CNT_W-1:0] HAY_LIM = CNT_W'(MAX_HAYSTACK);

	pattern_t           pattern_q;
	pat_len_t           pat_len_q;
	logic [CNT_W-1:0]   pos_q;
	logic               match_q;
	logic [OFS_W-1:0]   first_q;
	logic               ovf_q;
	logic               out_valid_q;
	logic               found_q;
	logic [OFS_W-1:0]   offset_q;
	logic               overflow_q;

	byte_t              win [MAX_PATTERN-1];
	logic [MAX_PATTERN-2:0] cell_hit;
	logic               accept;
	logic               in_range;
	logic               len_ok;
	logic               long_enough;
	logic               hit0;
	logic               new_match;
	logic [CNT_W:0]     start;
	logic [CNT_W+16:0]  start_x;
	logic [OFS_W-1:0]   start_sat;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			pat_len_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PAT_LOW:  pattern_q[63:0]   <= cfg_data;
				CFG_PAT_HIGH: pattern_q[127:64] <= cfg_data;
				CFG_PAT_LEN:  pat_len_q         <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	// cell chain
	assign win[0] = s_tdata;

	for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_cell
		if (k < MAX_PATTERN - 1) begin : g_mid
			bps_cell #(.CELL_IDX(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (accept),
				.byte_in  (win[k-1]),
				.pattern  (pattern_q),
				.pat_len  (pat_len_q),
				.byte_out (win[k]),
				.hit      (cell_hit[k-1])
			);
		end else begin : g_end
			bps_cell #(.CELL_IDX(k)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (accept),
				.byte_in  (win[k-1]),
				.pattern  (pattern_q),
				.pat_len  (pat_len_q),
				.byte_out (),
				.hit      (cell_hit[k-1])
			);
		end
	end

	// match decision
	assign hit0        = s_tdata == pat_byte(pattern_q, 4'(pat_len_q - LEN_W'(1)));
	assign in_range    = pos_q < HAY_LIM;
	assign len_ok      = (pat_len_q != '0) && (pat_len_q <= LEN_W'(MAX_PATTERN));
	assign long_enough = ((CNT_W+1)'(pos_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(pat_len_q);
	assign new_match   = in_range && !match_q && len_ok && long_enough && hit0 && (&cell_hit);
	assign start       = (CNT_W+1)'(pos_q) + (CNT_W+1)'(1) - (CNT_W+1)'(pat_len_q);
	assign start_x     = (CNT_W+17)'(start);
	assign start_sat   = (|start_x[CNT_W+16:16]) ? '1 : start_x[OFS_W-1:0];

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= 1'b0;
			first_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				pos_q   <= '0;
				match_q <= 1'b0;
				first_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (in_range) begin
					pos_q <= pos_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (new_match) begin
					match_q <= 1'b1;
					first_q <= start_sat;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && s_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			found_q    <= match_q || new_match;
			offset_q   <= match_q ? first_q : (new_match ? start_sat : '0);
			overflow_q <= ovf_q || !in_range;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, overflow_q, offset_q, found_q};

`ifndef SYNTH
	a_valid_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && s_tlast))
		else $error("result without last byte");

	a_no_result_mid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tlast && !out_valid_q |=> !out_valid_q)
		else $error("result on a byte that is not last");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0)
		else $error("offset set without match");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= HAY_LIM)
		else $error("position past haystack bound");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
// testbench for byte_pattern_search_top: directed and random haystacks checked against a local predictor
`timescale 1ns / 1ps
module tb_top;
	import bps_pkg::*;

	localparam int unsigned HAY_LIMIT = 65536;
	localparam int          DRAIN_GAP = 4;

	typedef struct {
		logic        found;
		logic [15:0] offset;
		logic        overflow;
	} search_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;   // found, match_offset[15:0], overflow, zero pad
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	byte_pattern_search_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of registers and stream state
	logic [63:0]    pat_lo, pat_hi;
	logic [4:0]     pat_len;
	byte_t          window [15];
	int unsigned    pos_count;
	bit             matched;
	logic [15:0]    first_ofs;
	bit             ovf_seen;

	search_result_t results_due [$];
	byte_t          haystack [$];
	int             mismatch_count = 0;
	int             bytes_sent = 0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             hold_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("byte_pattern_search_top regression: fail");
		$finish;
	end

	function automatic byte_t pattern_at(input int k);
		return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
	endfunction

	function automatic void clear_stream();
		foreach (window[i]) window[i] = '0;
		pos_count = 0;
		matched = 0;
		first_ofs = '0;
		ovf_seen = 0;
	endfunction

	function automatic void track_byte(input byte_t b, input logic last);
		int             len;
		bit             ok;
		int unsigned    start;
		search_result_t r;
		len = pat_len;
		if (pos_count < HAY_LIMIT) begin
			if (!matched && len >= 1 && len <= 16 && int'(pos_count) + 1 >= len) begin
				ok = (pattern_at(len - 1) == b);
				for (int k = 1; k < len; k++)
					if (pattern_at(len - 1 - k) != window[k-1])
						ok = 0;
				if (ok) begin
					start = pos_count + 1 - len;
					matched = 1;
					first_ofs = (start > 16'hFFFF) ? 16'hFFFF : start[15:0];
				end
			end
			pos_count++;
		end else begin
			ovf_seen = 1;
		end
		for (int i = 14; i > 0; i--)
			window[i] = window[i-1];
		window[0] = b;
		if (last) begin
			r.found = matched;
			r.offset = matched ? first_ofs : 16'h0;
			r.overflow = ovf_seen;
			results_due.push_back(r);
			clear_stream();
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		search_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0h", $time, m_tdata);
				mismatch_count++;
			end else begin
				exp_r = results_due.pop_front();
				if (m_tdata[0] !== exp_r.found) begin
					$display("%0t found: expected %0h actual %0h", $time, exp_r.found, m_tdata[0]);
					mismatch_count++;
				end
				if (m_tdata[16:1] !== exp_r.offset) begin
					$display("%0t match_offset: expected %0h actual %0h", $time, exp_r.offset,
						m_tdata[16:1]);
					mismatch_count++;
				end
				if (m_tdata[17] !== exp_r.overflow) begin
					$display("%0t overflow: expected %0h actual %0h", $time, exp_r.overflow,
						m_tdata[17]);
					mismatch_count++;
				end
				if (m_tdata[OUT_W-1:18] !== '0) begin
					$display("%0t pad bits: expected 0 actual %0h", $time, m_tdata[OUT_W-1:18]);
					mismatch_count++;
				end
			end
		end
	end

	// receiver with random stalls and long hold-offs
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic push_byte(input byte_t b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_haystack();
		foreach (haystack[i])
			push_byte(haystack[i], i == haystack.size() - 1);
		haystack.delete();
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_PAT_LOW:  pat_lo = v;
			CFG_PAT_HIGH: pat_hi = v;
			CFG_PAT_LEN:  pat_len = v[4:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pattern(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
		wait_drain();
		write_reg(CFG_PAT_LOW, lo);
		write_reg(CFG_PAT_HIGH, hi);
		write_reg(CFG_PAT_LEN, {$urandom, 27'($urandom), len});
	endtask

	task automatic random_haystack(input int max_len);
		int n, plen, at;
		n = $urandom_range(max_len, 1);
		plen = (pat_len > 16) ? 16 : int'(pat_len);
		for (int i = 0; i < n; i++)
			haystack.push_back((plen > 0 && $urandom_range(1)) ?
				pattern_at($urandom_range(plen - 1)) : byte_t'($urandom));
		if (plen > 0 && n >= plen && $urandom_range(3) != 0) begin
			at = $urandom_range(n - plen);
			for (int k = 0; k < plen; k++)
				haystack[at + k] = pattern_at(k);
		end
		send_haystack();
	endtask

	task automatic pick_random_pattern();
		logic [63:0] lo, hi;
		logic [4:0]  len;
		int          pick;
		pick = $urandom_range(19);
		if (pick == 0)
			len = 5'd0;
		else if (pick == 1)
			len = 5'($urandom_range(31, 17));
		else if (pick == 2)
			len = 5'd16;
		else
			len = 5'($urandom_range(16, 1));
		if ($urandom_range(1)) begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
		end else begin
			// two-letter alphabet gives self-overlapping patterns
			for (int i = 0; i < 64; i += 8) begin
				lo[i +: 8] = 8'h41 + 8'($urandom_range(1));
				hi[i +: 8] = 8'h41 + 8'($urandom_range(1));
			end
		end
		set_pattern(lo, hi, len);
	endtask

	task automatic test_zero_length();
		haystack = '{8'h00, 8'hFF};
		send_haystack();
	endtask

	task automatic test_single_byte();
		set_pattern(64'hFF, 64'h0, 5'd1);
		haystack = '{8'hFF};
		send_haystack();
		haystack = '{8'h00, 8'hFF, 8'hFF};
		send_haystack();
	endtask

	task automatic test_full_length();
		set_pattern('1, '0, 5'd16);
		repeat (2) begin
			for (int i = 0; i < 16; i++)
				haystack.push_back((i < 8) ? 8'hFF : 8'h00);
			send_haystack();
		end
		// one byte short of the pattern
		for (int i = 0; i < 15; i++)
			haystack.push_back((i < 8) ? 8'hFF : 8'h00);
		send_haystack();
	endtask

	task automatic test_overlap();
		set_pattern(64'h42_41_41, '0, 5'd3);
		haystack = '{8'h41, 8'h41, 8'h41, 8'h42, 8'h41, 8'h41, 8'h42};
		send_haystack();
	endtask

	task automatic test_oversize_length();
		set_pattern('0, '0, 5'd17);
		for (int i = 0; i < 20; i++)
			haystack.push_back(8'h00);
		send_haystack();
		set_pattern('0, '0, 5'd31);
		for (int i = 0; i < 20; i++)
			haystack.push_back(8'h00);
		send_haystack();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		pick_random_pattern();
		hold_cycles = 250;
		repeat (12)
			random_haystack(3);
		wait_drain();
	endtask

	task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n_bytes);
		int start;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick_random_pattern();
			repeat (5)
				random_haystack(40);
		end
		wait_drain();
	endtask

	initial begin
		pat_lo = '0;
		pat_hi = '0;
		pat_len = '0;
		clear_stream();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_length();
		test_single_byte();
		test_full_length();
		test_overlap();
		test_oversize_length();
		test_backpressure();
		test_random_phase(37, 84, 300);
		test_random_phase(84, 37, 300);
		test_random_phase(0, 0, 300);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("byte_pattern_search_top regression: pass");
		end else begin
			$display("byte_pattern_search_top regression: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/bps_pkg.sv
rtl/bps_cell.sv
rtl/byte_pattern_search_top.sv
tb/tb_top.sv
